>>> sv/ftma_pkg.sv
// ----------------------------------------------------------------------------
// ftma_pkg
// Shared types and constants for the five-tap moving average.
// ----------------------------------------------------------------------------
package ftma_pkg;

    localparam int WINDOW_TAPS = 5;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 19;
    localparam int MAG_W       = 18;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int RECIP_SHIFT = 20;
    localparam int HIST_DEPTH  = WINDOW_TAPS - 1;
    localparam int SEEN_W      = 3;
    localparam int PEND_DEPTH  = 3;
    localparam int PEND_CNT_W  = 2;

    // ceil(2^20 / 5); exact truncating quotient for magnitudes below 2^18
    localparam logic [MAG_W-1:0] RECIP_5 = 18'd209716;

    localparam logic [SEEN_W-1:0] SEEN_FULL = 3'd4;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    end_of_run;
        logic                    too_short;
    } res_t;

    typedef struct packed {
        logic valid;
        res_t res;
    } beat_t;

endpackage

>>> sv/five_tap_moving_average_with_edges.sv
// ----------------------------------------------------------------------------
// five_tap_moving_average_with_edges
// Path: a result is queued at the input beat that completes its window, then
// is registered in the ftma_div5 output register before it can leave.
// Throughput: one sample per cycle while the output does not stall; the last
// sample of a long stream holds off input while its three results are handed out.
// Reset: asynchronous; clears history, stream position and all valids.
// ----------------------------------------------------------------------------
module five_tap_moving_average_with_edges (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [ftma_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [ftma_pkg::SAMPLE_W-1:0] average,
    output logic                                 end_of_run,
    output logic                                 too_short
);
    import ftma_pkg::*;

    beat_t sum_beat;
    logic  sum_stall;

    ftma_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .last     (last),
        .dn_beat  (sum_beat),
        .dn_stall (sum_stall)
    );

    ftma_div5 u_div5 (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_beat    (sum_beat),
        .up_stall   (sum_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .average    (average),
        .end_of_run (end_of_run),
        .too_short  (too_short)
    );

endmodule

>>> sv/ftma_window.sv
// ----------------------------------------------------------------------------
// ftma_window
// Sample history, stream position and edge handling; builds up to three
// five-sample sums per input beat and hands them out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ftma_window (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [ftma_pkg::SAMPLE_W-1:0] sample,
    input  logic                            last,
    output ftma_pkg::beat_t                 dn_beat,
    input  logic                            dn_stall
);
    import ftma_pkg::*;

    logic signed [SAMPLE_W-1:0] hist_reg [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] hist_next [HIST_DEPTH];
    logic [SEEN_W-1:0]          seen_reg;
    logic [SEEN_W-1:0]          seen_next;
    res_t                       pend_reg [PEND_DEPTH];
    res_t                       pend_next [PEND_DEPTH];
    logic [PEND_CNT_W-1:0]      pend_cnt_reg;
    logic [PEND_CNT_W-1:0]      pend_cnt_next;

    res_t                       new_list [PEND_DEPTH];
    logic [PEND_CNT_W-1:0]      new_cnt;
    logic signed [SUM_W-1:0]    xe, xd, xc, xb, xa;
    logic signed [SUM_W-1:0]    mid_sum;
    logic                       have_mid;
    logic                       accept;
    logic                       move;

    assign move     = (pend_cnt_reg != '0) && !dn_stall;
    assign in_stall = !((pend_cnt_reg == '0) || ((pend_cnt_reg == 2'd1) && move));
    assign accept   = in_valid && !in_stall;

    assign dn_beat.valid = (pend_cnt_reg != '0);
    assign dn_beat.res   = pend_reg[0];

    assign xe = SUM_W'(sample);
    assign xd = SUM_W'(hist_reg[0]);
    assign xc = SUM_W'(hist_reg[1]);
    assign xb = SUM_W'(hist_reg[2]);
    assign xa = SUM_W'(hist_reg[3]);

    always_comb
    begin
        mid_sum  = '0;
        have_mid = 1'b0;
        priority if (seen_reg >= SEEN_FULL)
        begin
            mid_sum  = xa + xb + xc + xd + xe;
            have_mid = 1'b1;
        end
        else if (seen_reg == 3'd3)
        begin
            mid_sum  = xb + xc + xd + (xe <<< 1);
            have_mid = 1'b1;
        end
        else if (seen_reg == 3'd2)
        begin
            mid_sum  = xc + (xd <<< 1) + (xe <<< 1);
            have_mid = 1'b1;
        end
        else
        begin
            have_mid = 1'b0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < PEND_DEPTH; i++)
        begin
            new_list[i] = '0;
        end
        new_cnt = '0;
        priority if (last && (seen_reg < SEEN_FULL))
        begin
            new_list[0].end_of_run = 1'b1;
            new_list[0].too_short  = 1'b1;
            new_cnt                = 2'd1;
        end
        else if (last)
        begin
            new_list[0].sum        = mid_sum;
            new_list[1].sum        = xe + xd + xc + (xb <<< 1);
            new_list[2].sum        = xe + (xd <<< 1) + (xc <<< 1);
            new_list[2].end_of_run = 1'b1;
            new_cnt                = 2'd3;
        end
        else if (have_mid)
        begin
            new_list[0].sum = mid_sum;
            new_cnt         = 2'd1;
        end
        else
        begin
            new_cnt = '0;
        end
    end

    always_comb
    begin
        hist_next     = hist_reg;
        seen_next     = seen_reg;
        pend_next     = pend_reg;
        pend_cnt_next = pend_cnt_reg;
        if (accept)
        begin
            pend_next     = new_list;
            pend_cnt_next = new_cnt;
            if (last)
            begin
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    hist_next[i] = '0;
                end
                seen_next = '0;
            end
            else
            begin
                hist_next[0] = sample;
                for (int i = 1; i < HIST_DEPTH; i++)
                begin
                    hist_next[i] = hist_reg[i-1];
                end
                if (seen_reg < SEEN_FULL)
                begin
                    seen_next = seen_reg + 3'd1;
                end
            end
        end
        else if (move)
        begin
            for (int i = 0; i < PEND_DEPTH - 1; i++)
            begin
                pend_next[i] = pend_reg[i+1];
            end
            pend_cnt_next = pend_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
            seen_reg     <= '0;
            pend_cnt_reg <= '0;
        end
        else
        begin
            hist_reg     <= hist_next;
            seen_reg     <= seen_next;
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_FULL)
        else $error("seen count beyond saturation");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> (seen_reg == '0) && (hist_reg[0] == '0))
        else $error("stream state not cleared after last beat");

    a_full_tail: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last && (seen_reg >= SEEN_FULL) |=>
            (pend_cnt_reg == 2'd3) && pend_reg[2].end_of_run && !pend_reg[0].end_of_run)
        else $error("long stream tail not queued as three results");

    a_warmup_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last && (seen_reg < 3'd2) |=> (pend_cnt_reg == '0))
        else $error("result emitted during window warm-up");

endmodule

>>> sv/ftma_div5.sv
// ----------------------------------------------------------------------------
// ftma_div5
// Divides a window sum by five, truncating toward zero, via a reciprocal
// multiply; holds the result beat in the output register.
// ----------------------------------------------------------------------------
module ftma_div5 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ftma_pkg::beat_t                 up_beat,
    output logic                            up_stall,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [ftma_pkg::SAMPLE_W-1:0] average,
    output logic                            end_of_run,
    output logic                            too_short
);
    import ftma_pkg::*;

    logic                       valid_reg;
    logic                       valid_next;
    logic signed [SAMPLE_W-1:0] average_reg;
    logic signed [SAMPLE_W-1:0] average_next;
    logic                       eor_reg;
    logic                       short_reg;

    logic                       neg;
    logic [SUM_W-1:0]           abs_sum;
    logic [MAG_W-1:0]           mag;
    logic [PROD_W-1:0]          prod;
    logic [SAMPLE_W-1:0]        quot;
    logic                       take;

    assign up_stall = valid_reg && out_stall;
    assign take     = up_beat.valid && !up_stall;

    assign neg     = up_beat.res.sum[SUM_W-1];
    assign abs_sum = neg ? (-up_beat.res.sum) : up_beat.res.sum;
    assign mag     = abs_sum[MAG_W-1:0];
    assign prod    = PROD_W'(mag) * PROD_W'(RECIP_5);
    assign quot    = prod[RECIP_SHIFT +: SAMPLE_W];

    assign average_next = neg ? (-$signed(quot)) : $signed(quot);

    always_comb
    begin
        valid_next = valid_reg;
        if (!up_stall)
        begin
            valid_next = up_beat.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            average_reg <= average_next;
            eor_reg     <= up_beat.res.end_of_run;
            short_reg   <= up_beat.res.too_short;
        end
    end

    assign out_valid  = valid_reg;
    assign average    = average_reg;
    assign end_of_run = eor_reg;
    assign too_short  = short_reg;

    a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && short_reg |-> eor_reg && (average_reg == '0))
        else $error("error result malformed");

    a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
        take && !neg |=> !average_reg[SAMPLE_W-1])
        else $error("non-negative sum gave negative average");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_stall |=> valid_reg && $stable(average_reg))
        else $error("stalled result changed");

endmodule

>>> sim/ftma_window_checker.sv
// ----------------------------------------------------------------------------
// ftma_window_checker
// Watches both channels of the five-tap moving average, keeps its own copy of
// the sample window and stream position, works out the averages owed for each
// accepted input beat and compares every accepted output beat against them.
// ----------------------------------------------------------------------------
module ftma_window_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic signed [ftma_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 last,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [ftma_pkg::SAMPLE_W-1:0] average,
    input  logic                                 end_of_run,
    input  logic                                 too_short,
    output int                                   mismatches,
    output int                                   results_owed
);
    timeunit 1ns;
    timeprecision 1ps;
    import ftma_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic                       end_of_run;
        logic                       too_short;
    } avg_result_t;

    logic signed [SAMPLE_W-1:0] past [HIST_DEPTH];
    logic [SEEN_W-1:0]          seen;
    avg_result_t                owed_q [$];
    int                         fail_total;

    function automatic avg_result_t make_result(int sum, logic eor, logic shrt);
        avg_result_t r;
        r.average    = SAMPLE_W'(sum / WINDOW_TAPS);
        r.end_of_run = eor;
        r.too_short  = shrt;
        return r;
    endfunction

    task automatic clear_window();
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            past[i] = '0;
        end
        seen = '0;
    endtask

    task automatic predict_averages(input logic signed [SAMPLE_W-1:0] s, input logic l);
        int a, b, c, d, e;
        e = s;
        d = past[0];
        c = past[1];
        b = past[2];
        a = past[3];
        if (l && seen < SEEN_FULL)
        begin
            owed_q.push_back(make_result(0, 1'b1, 1'b1));
            clear_window();
            return;
        end
        if (seen == 3'd2)
            owed_q.push_back(make_result(c + 2 * d + 2 * e, 1'b0, 1'b0));
        else if (seen == 3'd3)
            owed_q.push_back(make_result(b + c + d + 2 * e, 1'b0, 1'b0));
        else if (seen >= SEEN_FULL)
            owed_q.push_back(make_result(a + b + c + d + e, 1'b0, 1'b0));
        if (l)
        begin
            owed_q.push_back(make_result(e + d + c + 2 * b, 1'b0, 1'b0));
            owed_q.push_back(make_result(e + 2 * d + 2 * c, 1'b1, 1'b0));
            clear_window();
            return;
        end
        for (int i = HIST_DEPTH - 1; i > 0; i--)
        begin
            past[i] = past[i-1];
        end
        past[0] = s;
        if (seen < SEEN_FULL)
            seen = seen + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        avg_result_t got, want;
        if (!rst_n)
        begin
            clear_window();
            owed_q.delete();
            fail_total = 0;
            mismatches   <= 0;
            results_owed <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_averages(sample, last);
            if (out_valid && !out_stall)
            begin
                got.average    = average;
                got.end_of_run = end_of_run;
                got.too_short  = too_short;
                if (owed_q.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("%0t: unexpected beat: average=%0d end_of_run=%b too_short=%b",
                                 $realtime, got.average, got.end_of_run, got.too_short);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (got.average !== want.average || got.end_of_run !== want.end_of_run ||
                        got.too_short !== want.too_short)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                            $display(
                                "%0t: mismatch: expected %0d/%b/%b, actual %0d/%b/%b",
                                $realtime, want.average, want.end_of_run, want.too_short,
                                got.average, got.end_of_run, got.too_short);
                    end
                end
            end
            mismatches   <= fail_total;
            results_owed <= owed_q.size();
        end
    end

endmodule

>>> sim/five_tap_moving_average_with_edges_tb.sv
// ----------------------------------------------------------------------------
// five_tap_moving_average_with_edges_tb
// Drives framed sample streams into the moving average: short streams that
// must give the error beat, extreme and sign-mixed windows, then random
// streams of varied length and content. The sender idles in bursts and the
// receiver stalls on a rotating pattern; a checker scores every output beat.
// ----------------------------------------------------------------------------
module five_tap_moving_average_with_edges_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ftma_pkg::*;

    localparam int RANDOM_ITEMS = 120;
    localparam int QUIET_LIMIT  = 200;
    localparam int DRAIN_CYCLES = 8;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       last = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] average;
    logic                       end_of_run;
    logic                       too_short;
    int                         mismatches;
    int                         results_owed;

    int                         burst_left = 0;
    logic                       no_idle = 1'b1;
    int                         quiet_cycles = 0;
    logic [7:0]                 stall_pattern = '0;
    int                         stall_step = 0;
    int                         stall_rounds = 0;

    five_tap_moving_average_with_edges DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .average    (average),
        .end_of_run (end_of_run),
        .too_short  (too_short)
    );

    ftma_window_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .average      (average),
        .end_of_run   (end_of_run),
        .too_short    (too_short),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver stall pattern; bit 0 kept clear so a stall never spans a whole pattern round
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= stall_pattern[stall_step];
            stall_step = (stall_step + 1) % 8;
            if (stall_step == 0)
            begin
                stall_rounds++;
                if (stall_rounds % 8 == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: stall_pattern = 8'h00;
                        1: stall_pattern = 8'($urandom) & 8'hFE;
                        2: stall_pattern = 8'hFE;
                        default: stall_pattern = 8'($urandom & $urandom) & 8'hFE;
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("** five_tap_moving_average_with_edges: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic signed [SAMPLE_W-1:0] s, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                sample   <= SAMPLE_W'($urandom);
                last     <= 1'($urandom);
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= s;
        last     <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial
    begin
        int                         items, len, flavor, pick;
        logic signed [SAMPLE_W-1:0] s;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // streams of one to four samples: error beat, with out0 first for four
        for (int n = 1; n <= 4; n++)
        begin
            for (int k = 0; k < n; k++)
            begin
                send_beat(SAMPLE_W'(k * 1000 - 1), k == n - 1);
            end
        end
        for (int k = 0; k < 5; k++)
        begin
            send_beat(16'sh7FFF, k == 4);
        end
        for (int k = 0; k < 5; k++)
        begin
            send_beat(16'sh8000, k == 4);
        end
        // sign-mixed window, negative sums truncate toward zero
        send_beat(-16'sd1, 1'b0);
        send_beat(16'sd2, 1'b0);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh7FFF, 1'b0);
        send_beat(-16'sd3, 1'b1);

        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                len = $urandom_range(1, 4);
            else if (pick == 1)
                len = $urandom_range(20, 40);
            else
                len = $urandom_range(5, 12);
            flavor  = $urandom_range(0, 3);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++)
            begin
                case (flavor)
                    0: s = SAMPLE_W'($urandom);
                    1: s = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
                    2: s = SAMPLE_W'($urandom_range(0, 40)) - 16'sd20;
                    default: s = ($urandom_range(0, 2) == 0) ? SAMPLE_W'($urandom)
                                                              : SAMPLE_W'($urandom_range(0, 9));
                endcase
                send_beat(s, k == len - 1);
            end
            items += len;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (results_owed != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && results_owed == 0)
            $display("** five_tap_moving_average_with_edges: PASSED **");
        else
            $display("** five_tap_moving_average_with_edges: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
sv/ftma_pkg.sv
sv/ftma_window.sv
sv/ftma_div5.sv
sv/five_tap_moving_average_with_edges.sv
sim/ftma_window_checker.sv
sim/five_tap_moving_average_with_edges_tb.sv
